// ===== sv/text_console_line_editor_macros.svh =====
// Assertion macros used by the console editor sequencer.
`ifndef TEXT_CONSOLE_LINE_EDITOR_MACROS_SVH
`define TEXT_CONSOLE_LINE_EDITOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TCLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcle_pkg.sv =====
// Shared constants, types and state codes of the console line editor.
package tcle_pkg;

  // Default geometry and line size
  localparam int unsigned DefColumns      = 40;
  localparam int unsigned DefRows         = 23;
  localparam int unsigned DefLineCapacity = 100;

  // Field widths of the item channels
  localparam int unsigned KeyW    = 8;
  localparam int unsigned CellW   = 8;
  localparam int unsigned InAddrW = 10;
  localparam int unsigned OutPosW = 10;
  localparam int unsigned OutLenW = 7;

  // Special characters
  localparam logic [KeyW-1:0] KeyBackspace = 8'h08;
  localparam logic [KeyW-1:0] KeyEnter     = 8'h0A;
  localparam logic [KeyW-1:0] PromptChar   = 8'h3E;

  // Item commands
  localparam logic CmdKey  = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    TCLE_CLEAR,
    TCLE_IDLE,
    TCLE_READ,
    TCLE_BKSP,
    TCLE_NEWLINE,
    TCLE_PUT,
    TCLE_CHECK,
    TCLE_PRIME,
    TCLE_COPY,
    TCLE_BLANK,
    TCLE_UNSCROLL,
    TCLE_EMIT
  } tcle_state_e;

  // One result item
  typedef struct packed {
    logic [CellW-1:0]   cell_value;
    logic [OutPosW-1:0] cursor_position;
    logic [OutLenW-1:0] line_length;
    logic               scrolled;
  } tcle_result_t;

endpackage

// ===== sv/tcle_if.sv =====
// Item channel interfaces of the console line editor.
interface tcle_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [tcle_pkg::KeyW-1:0]      key_code;
  logic [tcle_pkg::InAddrW-1:0]   cell_address;

  modport source (output valid, command, key_code, cell_address, input ready);
  modport sink   (input valid, command, key_code, cell_address, output ready);
endinterface

interface tcle_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tcle_pkg::CellW-1:0]     cell_value;
  logic [tcle_pkg::OutPosW-1:0]   cursor_position;
  logic [tcle_pkg::OutLenW-1:0]   line_length;
  logic                           scrolled;

  modport source (output valid, cell_value, cursor_position, line_length, scrolled,
                  input ready);
  modport sink   (input valid, cell_value, cursor_position, line_length, scrolled,
                  output ready);
endinterface

// ===== sv/tcle_screen_ram.sv =====
// Screen character store: one write port, one registered read port.
module tcle_screen_ram #(
  parameter int unsigned Depth = tcle_pkg::DefColumns * tcle_pkg::DefRows,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [tcle_pkg::CellW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [tcle_pkg::CellW-1:0] rdata_o
);

  logic [tcle_pkg::CellW-1:0] mem_q [Depth];
  logic [tcle_pkg::CellW-1:0] rdata_q;

  // Write one cell
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one cell into the registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcle_addr_alu.sv =====
// Shared address adder/subtractor with a screen-end compare.
module tcle_addr_alu #(
  parameter int unsigned Width = 11,
  parameter int unsigned Limit = tcle_pkg::DefColumns * tcle_pkg::DefRows
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             sub_i,
  output logic [Width-1:0] sum_o,
  output logic             ge_o
);

  // Add or subtract, then flag a result past the last cell
  always_comb begin
    if (sub_i) begin
      sum_o = a_i - b_i;
    end else begin
      sum_o = a_i + b_i;
    end
    ge_o = (sum_o >= Width'(Limit));
  end

endmodule

// ===== sv/tcle_ctrl.sv =====
// Sequencer of the console editor: keys, reads, scroll and clearing sweeps.
`include "text_console_line_editor_macros.svh"

module tcle_ctrl #(
  parameter int unsigned COLUMNS       = tcle_pkg::DefColumns,
  parameter int unsigned ROWS          = tcle_pkg::DefRows,
  parameter int unsigned LINE_CAPACITY = tcle_pkg::DefLineCapacity,
  parameter int unsigned CellCount     = COLUMNS * ROWS,
  parameter int unsigned AddrW         = $clog2(CellCount),
  parameter int unsigned WideW         = AddrW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcle_req_if.sink                   req_i,
  output logic                       res_valid_o,
  output tcle_pkg::tcle_result_t     res_o,
  input  logic                       res_ready_i,
  output logic [WideW-1:0]           alu_a_o,
  output logic [WideW-1:0]           alu_b_o,
  output logic                       alu_sub_o,
  input  logic [WideW-1:0]           alu_sum_i,
  input  logic                       alu_ge_i,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [tcle_pkg::CellW-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [tcle_pkg::CellW-1:0] mem_rdata_i
);

  localparam int unsigned MoveCount = (ROWS - 1) * COLUMNS;
  localparam int unsigned ColW      = $clog2(COLUMNS + 1);
  localparam int unsigned LenW      = $clog2(LINE_CAPACITY);

  tcle_pkg::tcle_state_e state_q, state_d;

  logic [WideW-1:0]           cursor_q, cursor_d;
  logic [ColW-1:0]            rem_q, rem_d;       // cells left in the current row
  logic [LenW-1:0]            len_q, len_d;
  logic [AddrW-1:0]           sc_q, sc_d;         // sweep index
  logic                       put_pend_q, put_pend_d;
  logic                       scrolled_q, scrolled_d;
  logic [tcle_pkg::KeyW-1:0]  char_q, char_d;
  logic [tcle_pkg::CellW-1:0] value_q, value_d;
  logic                       in_range_q, in_range_d;

  logic                       accept;
  logic [AddrW+tcle_pkg::InAddrW-1:0] addr_ext;
  logic                       addr_ok;
  logic                       sc_last_cell;
  logic                       sc_last_move;
  logic [WideW+tcle_pkg::OutPosW-1:0] cur_ext;
  logic [LenW+tcle_pkg::OutLenW-1:0]  len_ext;

  assign req_i.ready  = (state_q == tcle_pkg::TCLE_IDLE);
  assign accept       = req_i.valid && req_i.ready;
  assign addr_ext     = (AddrW + tcle_pkg::InAddrW)'(req_i.cell_address);
  assign addr_ok      = (addr_ext < (AddrW + tcle_pkg::InAddrW)'(CellCount));
  assign sc_last_cell = (sc_q == AddrW'(CellCount - 1));
  assign sc_last_move = (sc_q == AddrW'(MoveCount - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcle_pkg::TCLE_CLEAR: begin
        if (sc_last_cell) state_d = tcle_pkg::TCLE_IDLE;
      end
      tcle_pkg::TCLE_IDLE: begin
        if (accept) begin
          if (req_i.command == tcle_pkg::CmdRead) begin
            state_d = tcle_pkg::TCLE_READ;
          end else if (req_i.key_code == tcle_pkg::KeyBackspace) begin
            state_d = (len_q != '0) ? tcle_pkg::TCLE_BKSP : tcle_pkg::TCLE_EMIT;
          end else if (req_i.key_code == tcle_pkg::KeyEnter) begin
            state_d = tcle_pkg::TCLE_NEWLINE;
          end else if (len_q < LenW'(LINE_CAPACITY - 1)) begin
            state_d = tcle_pkg::TCLE_PUT;
          end else begin
            state_d = tcle_pkg::TCLE_EMIT;
          end
        end
      end
      tcle_pkg::TCLE_READ:     state_d = tcle_pkg::TCLE_EMIT;
      tcle_pkg::TCLE_BKSP:     state_d = tcle_pkg::TCLE_EMIT;
      tcle_pkg::TCLE_NEWLINE:  state_d = tcle_pkg::TCLE_CHECK;
      tcle_pkg::TCLE_PUT:      state_d = tcle_pkg::TCLE_CHECK;
      tcle_pkg::TCLE_CHECK: begin
        if (alu_ge_i) begin
          state_d = tcle_pkg::TCLE_PRIME;
        end else if (put_pend_q) begin
          state_d = tcle_pkg::TCLE_PUT;
        end else begin
          state_d = tcle_pkg::TCLE_EMIT;
        end
      end
      tcle_pkg::TCLE_PRIME:    state_d = tcle_pkg::TCLE_COPY;
      tcle_pkg::TCLE_COPY: begin
        if (sc_last_move) state_d = tcle_pkg::TCLE_BLANK;
      end
      tcle_pkg::TCLE_BLANK: begin
        if (sc_last_cell) state_d = tcle_pkg::TCLE_UNSCROLL;
      end
      tcle_pkg::TCLE_UNSCROLL: state_d = tcle_pkg::TCLE_CHECK;
      tcle_pkg::TCLE_EMIT: begin
        if (res_ready_i) state_d = tcle_pkg::TCLE_IDLE;
      end
      default:                 state_d = tcle_pkg::TCLE_IDLE;
    endcase
  end

  // Drive the shared adder and the screen store ports
  always_comb begin
    alu_a_o     = cursor_q;
    alu_b_o     = '0;
    alu_sub_o   = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cursor_q[AddrW-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_ext[AddrW-1:0];
    res_valid_o = 1'b0;
    unique case (state_q)
      tcle_pkg::TCLE_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sc_q;
        mem_wdata_o = (sc_q == '0) ? tcle_pkg::PromptChar : '0;
      end
      tcle_pkg::TCLE_IDLE: begin
        alu_b_o   = WideW'(1);
        alu_sub_o = 1'b1;
        mem_re_o  = accept && (req_i.command == tcle_pkg::CmdRead) && addr_ok;
      end
      tcle_pkg::TCLE_BKSP: begin
        mem_we_o = 1'b1;
      end
      tcle_pkg::TCLE_NEWLINE: begin
        alu_b_o = WideW'(rem_q);
      end
      tcle_pkg::TCLE_PUT: begin
        alu_b_o     = WideW'(1);
        mem_we_o    = 1'b1;
        mem_wdata_o = char_q;
      end
      tcle_pkg::TCLE_PRIME: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AddrW'(COLUMNS);
      end
      tcle_pkg::TCLE_COPY: begin
        alu_a_o     = WideW'(sc_q);
        alu_b_o     = WideW'(COLUMNS + 1);
        mem_we_o    = 1'b1;
        mem_waddr_o = sc_q;
        mem_wdata_o = mem_rdata_i;
        mem_re_o    = !sc_last_move;
        mem_raddr_o = alu_sum_i[AddrW-1:0];
      end
      tcle_pkg::TCLE_BLANK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sc_q;
      end
      tcle_pkg::TCLE_UNSCROLL: begin
        alu_b_o   = WideW'(COLUMNS);
        alu_sub_o = 1'b1;
      end
      tcle_pkg::TCLE_EMIT: begin
        res_valid_o = res_ready_i;
      end
      default: begin
        alu_b_o = '0;
      end
    endcase
  end

  // Register next values
  always_comb begin
    cursor_d   = cursor_q;
    rem_d      = rem_q;
    len_d      = len_q;
    sc_d       = sc_q;
    put_pend_d = put_pend_q;
    scrolled_d = scrolled_q;
    char_d     = char_q;
    value_d    = value_q;
    in_range_d = in_range_q;
    case (state_q)
      tcle_pkg::TCLE_CLEAR: begin
        sc_d = sc_last_cell ? '0 : sc_q + AddrW'(1);
      end
      tcle_pkg::TCLE_IDLE: begin
        if (accept) begin
          scrolled_d = 1'b0;
          value_d    = '0;
          in_range_d = addr_ok;
          put_pend_d = 1'b0;
          char_d     = req_i.key_code;
          if (req_i.command == tcle_pkg::CmdKey) begin
            if (req_i.key_code == tcle_pkg::KeyBackspace) begin
              // Shorten the line and step the cursor back
              if (len_q != '0) begin
                len_d = len_q - LenW'(1);
                if (cursor_q != '0) begin
                  cursor_d = alu_sum_i;
                  rem_d    = (rem_q == ColW'(COLUMNS)) ? ColW'(1) : rem_q + ColW'(1);
                end
              end
            end else if (req_i.key_code == tcle_pkg::KeyEnter) begin
              len_d      = '0;
              put_pend_d = 1'b1;
              char_d     = tcle_pkg::PromptChar;
            end else if (len_q < LenW'(LINE_CAPACITY - 1)) begin
              len_d = len_q + LenW'(1);
            end
          end
        end
      end
      tcle_pkg::TCLE_READ: begin
        value_d = in_range_q ? mem_rdata_i : '0;
      end
      tcle_pkg::TCLE_NEWLINE: begin
        cursor_d = alu_sum_i;
        rem_d    = ColW'(COLUMNS);
      end
      tcle_pkg::TCLE_PUT: begin
        cursor_d   = alu_sum_i;
        rem_d      = (rem_q == ColW'(1)) ? ColW'(COLUMNS) : rem_q - ColW'(1);
        put_pend_d = 1'b0;
      end
      tcle_pkg::TCLE_CHECK: begin
        if (alu_ge_i) begin
          sc_d       = '0;
          scrolled_d = 1'b1;
        end
      end
      tcle_pkg::TCLE_COPY: begin
        sc_d = sc_q + AddrW'(1);
      end
      tcle_pkg::TCLE_BLANK: begin
        sc_d = sc_last_cell ? '0 : sc_q + AddrW'(1);
      end
      tcle_pkg::TCLE_UNSCROLL: begin
        cursor_d = alu_sum_i;
      end
      default: begin
        sc_d = sc_q;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcle_pkg::TCLE_CLEAR;
      cursor_q   <= WideW'(1);
      rem_q      <= ColW'(COLUMNS - 1);
      len_q      <= '0;
      sc_q       <= '0;
      put_pend_q <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      rem_q      <= rem_d;
      len_q      <= len_d;
      sc_q       <= sc_d;
      put_pend_q <= put_pend_d;
      scrolled_q <= scrolled_d;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    value_q    <= value_d;
    in_range_q <= in_range_d;
  end

  // Mask wide values to the result field widths
  assign cur_ext = (WideW + tcle_pkg::OutPosW)'(cursor_q);
  assign len_ext = (LenW + tcle_pkg::OutLenW)'(len_q);

  assign res_o.cell_value      = value_q;
  assign res_o.cursor_position = cur_ext[tcle_pkg::OutPosW-1:0];
  assign res_o.line_length     = len_ext[tcle_pkg::OutLenW-1:0];
  assign res_o.scrolled        = scrolled_q;

  `TCLE_ASSERT_IMP(a_cursor_on_screen, clk_i, rst_ni, state_q == tcle_pkg::TCLE_IDLE, cursor_q < WideW'(CellCount), "cursor beyond screen while idle")
  `TCLE_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= LenW'(LINE_CAPACITY - 1), "line length over capacity")
  `TCLE_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, 1'b1, (rem_q != '0) && (rem_q <= ColW'(COLUMNS)), "row remainder out of range")
  `TCLE_ASSERT_NXT(a_scroll_start, clk_i, rst_ni, (state_q == tcle_pkg::TCLE_CHECK) && alu_ge_i, state_q == tcle_pkg::TCLE_PRIME, "cursor past bottom without scroll")
  `TCLE_ASSERT_IMP(a_res_slot_free, clk_i, rst_ni, res_valid_o, res_ready_i, "result issued into a full output register")

endmodule

// ===== sv/text_console_line_editor.sv =====
// Top level of the console line editor: sequencer, shared adder, screen store, output register.
//
//   channel | dir | carries
//   --------+-----+----------------------------------------------------
//   req_i   | in  | command, key_code, cell_address
//   rsp_o   | out | cell_value, cursor_position, line_length, scrolled
//
// A cell read passes READ and EMIT, a printable key PUT, CHECK and EMIT, an enter
// NEWLINE, CHECK, PUT, CHECK and EMIT. A key that moves the cursor past the bottom row
// scrolls the screen, copying and blanking one cell a cycle through the single store
// write port. After reset a clearing pass over every cell runs before the first item is
// taken. One item is in work at a time; the next one is taken while a result still waits
// in the output register, and a finished item holds until that register is free.
module text_console_line_editor #(
  parameter int unsigned COLUMNS       = tcle_pkg::DefColumns,
  parameter int unsigned ROWS          = tcle_pkg::DefRows,
  parameter int unsigned LINE_CAPACITY = tcle_pkg::DefLineCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcle_req_if.sink  req_i,
  tcle_rsp_if.source rsp_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned WideW     = AddrW + 1;

  logic                       res_valid;
  logic                       res_ready;
  tcle_pkg::tcle_result_t     res;
  logic [WideW-1:0]           alu_a, alu_b, alu_sum;
  logic                       alu_sub, alu_ge;
  logic                       mem_we, mem_re;
  logic [AddrW-1:0]           mem_waddr, mem_raddr;
  logic [tcle_pkg::CellW-1:0] mem_wdata, mem_rdata;

  logic                       out_valid_q;
  tcle_pkg::tcle_result_t     out_q;

  tcle_ctrl #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .LINE_CAPACITY (LINE_CAPACITY),
    .CellCount     (CellCount),
    .AddrW         (AddrW),
    .WideW         (WideW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_sub_o   (alu_sub),
    .alu_sum_i   (alu_sum),
    .alu_ge_i    (alu_ge),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcle_addr_alu #(
    .Width (WideW),
    .Limit (CellCount)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  tcle_screen_ram #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register is free when empty or being taken this cycle
  assign res_ready = !out_valid_q || rsp_o.ready;

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.cell_value      = out_q.cell_value;
  assign rsp_o.cursor_position = out_q.cursor_position;
  assign rsp_o.line_length     = out_q.line_length;
  assign rsp_o.scrolled        = out_q.scrolled;

endmodule
